@@ rtl/cbq_pkg.sv @@
// cbq_pkg: shared constants, codes, state type and command struct of the biquad cascade
// used by cbq_ctrl, cbq_datapath and cascaded_biquad_iir_filter; no dependencies
package cbq_pkg;

    // storage and field sizes
    localparam int MAX_SECTIONS = 8;
    localparam int SAMPLE_W     = 16;
    localparam int COEF_W       = 20;
    localparam int DELAY_W      = 32;
    localparam int CFG_W        = 4;
    localparam int ACTION_W     = 2;
    localparam int SECTION_W    = 3;
    localparam int SEL_W        = 3;
    localparam int NUM_COEFS    = 5;

    localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

    // fixed-point alignment: all sums are exact with ACC_FRAC fractional bits
    localparam int COEF_FRAC  = 16;
    localparam int DELAY_FRAC = 24;
    localparam int ACC_FRAC   = 40;
    localparam int P_W        = COEF_W + SAMPLE_W;
    localparam int UP_SH      = ACC_FRAC - (SAMPLE_W - 1) - COEF_FRAC;
    localparam int DUP_SH     = ACC_FRAC - DELAY_FRAC;
    localparam int Y_SH       = ACC_FRAC - (SAMPLE_W - 1);
    localparam int Z_SH       = ACC_FRAC - DELAY_FRAC;
    localparam int ACC_W      = DELAY_W + DUP_SH + 2;

    localparam logic signed [ACC_W-1:0] Y_MAX  = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Z_MAX  = (ACC_W'(1) <<< (DELAY_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_HALF = ACC_W'(1) <<< (Y_SH - 1);
    localparam logic signed [ACC_W-1:0] Z_HALF = ACC_W'(1) <<< (Z_SH - 1);

    // stream packing
    localparam int S_TDATA_BITS = SAMPLE_W + SECTION_W + COEF_W;
    localparam int S_TDATA_W    = ((S_TDATA_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W    = ACTION_W + SEL_W;
    localparam int M_TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;

    localparam int SEC_LSB  = SAMPLE_W;
    localparam int COEF_LSB = SAMPLE_W + SECTION_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_FILTER = 2'd0,
        ACT_COEF   = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [SEL_W-1:0] {
        SEL_B0 = 3'd0,
        SEL_B1 = 3'd1,
        SEL_B2 = 3'd2,
        SEL_A1 = 3'd3,
        SEL_A2 = 3'd4
    } t_coef_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL_X,
        S_SAT_Y,
        S_MUL_Y,
        S_UPDATE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             load_x;
        logic             coef_wr;
        logic [SEC_W-1:0] coef_sec;
        logic             delay_clr;
        logic             rd_en;
        logic [SEC_W-1:0] rd_idx;
        logic             mul_x;
        logic             sat_y;
        logic             mul_y;
        logic             upd;
        logic [SEC_W-1:0] upd_idx;
        logic             ld_out;
    } t_dp_cmd;

endpackage

@@ rtl/cbq_ctrl.sv @@
// cbq_ctrl: sequencer of the biquad cascade, section counter, handshakes and config register
// depends on cbq_pkg
module cbq_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [cbq_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic                         i_s_valid,
    input  logic [cbq_pkg::ACTION_W-1:0] i_action,
    input  logic [cbq_pkg::SECTION_W-1:0] i_section,
    input  logic                         i_m_ready,
    output logic                         o_s_ready,
    output logic                         o_m_valid,
    output cbq_pkg::t_dp_cmd             o_cmd
);
    import cbq_pkg::*;

    t_state           r_state, n_state;
    logic [SEC_W-1:0] r_sec, n_sec;
    logic [CFG_W-1:0] r_num_sections;
    logic             r_out_valid, n_out_valid;

    logic [CNT_W-1:0] n_eff;
    logic             last_sec;
    logic             sec_ok;
    logic             accept;

    // sections in use, bounded to 1..MAX_SECTIONS
    always_comb begin
        if (r_num_sections == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(r_num_sections) > MAX_SECTIONS) begin
            n_eff = CNT_W'(MAX_SECTIONS);
        end else begin
            n_eff = CNT_W'(r_num_sections);
        end
    end

    assign last_sec  = (({1'b0, r_sec} + (SEC_W+1)'(1)) == (SEC_W+1)'(n_eff));
    assign sec_ok    = (32'(i_section) < MAX_SECTIONS);
    assign o_s_ready = (r_state == S_IDLE);
    assign accept    = i_s_valid && o_s_ready;
    assign o_m_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sec          <= '0;
            r_num_sections <= CFG_W'(1);
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sec       <= n_sec;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_num_sections <= i_cfg_wr_data;
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        n_sec          = r_sec;
        n_out_valid    = r_out_valid;
        o_cmd          = '0;
        o_cmd.coef_sec = SEC_W'(i_section);
        o_cmd.upd_idx  = r_sec;
        o_cmd.rd_idx   = r_sec;

        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_FILTER: begin
                            o_cmd.load_x = 1'b1;
                            n_sec        = '0;
                            n_state      = S_READ;
                        end
                        ACT_COEF: begin
                            o_cmd.coef_wr = sec_ok;
                        end
                        ACT_CLEAR: begin
                            o_cmd.delay_clr = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_MUL_X;
            end
            S_MUL_X: begin
                o_cmd.mul_x = 1'b1;
                n_state     = S_SAT_Y;
            end
            S_SAT_Y: begin
                o_cmd.sat_y = 1'b1;
                n_state     = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_cmd.mul_y = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.upd = 1'b1;
                if (last_sec) begin
                    n_state = S_OUT;
                end else begin
                    // fetch the next section while this one is written back
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_idx = r_sec + SEC_W'(1);
                    n_sec        = r_sec + SEC_W'(1);
                    n_state      = S_MUL_X;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cbq_datapath.sv @@
// cbq_datapath: coefficient and delay memories, multipliers, rounding and saturation
// depends on cbq_pkg; driven by commands from cbq_ctrl
module cbq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbq_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [cbq_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [cbq_pkg::SEL_W-1:0]         i_coef_select,
    input  logic signed [cbq_pkg::COEF_W-1:0] i_coef_value,
    output logic signed [cbq_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                              o_saturated
);
    import cbq_pkg::*;

    function automatic logic signed [ACC_W-1:0] clamp(
        input logic signed [ACC_W-1:0] v,
        input logic signed [ACC_W-1:0] hi
    );
        if (v > hi) begin
            return hi;
        end else if (v < ~hi) begin
            return ~hi;
        end
        return v;
    endfunction

    // coefficient banks, one per coefficient kind, and delay rows
    logic signed [COEF_W-1:0]  mem_coef [NUM_COEFS][MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0]   r_coef_valid [NUM_COEFS];
    logic signed [DELAY_W-1:0] mem_z0 [MAX_SECTIONS];
    logic signed [DELAY_W-1:0] mem_z1 [MAX_SECTIONS];
    logic [MAX_SECTIONS-1:0]   r_z_valid;

    logic signed [COEF_W-1:0]   r_coef [NUM_COEFS];
    logic signed [DELAY_W-1:0]  r_z0, r_z1;
    logic signed [SAMPLE_W-1:0] r_x, r_y;
    logic signed [P_W-1:0]      r_p0, r_p1, r_p2, r_q1, r_q2;
    logic                       r_flag;
    logic signed [SAMPLE_W-1:0] r_res_sample;
    logic                       r_res_sat;

    logic                       sel_ok;
    logic signed [ACC_W-1:0]    acc_y, acc_z0, acc_z1;
    logic signed [ACC_W-1:0]    sh_y, sh_z0, sh_z1;
    logic signed [SAMPLE_W-1:0] y_new;
    logic signed [DELAY_W-1:0]  z0_new, z1_new;
    logic                       y_ovf, z_ovf;

    always_comb begin
        case (t_coef_sel'(i_coef_select))
            SEL_B0, SEL_B1, SEL_B2, SEL_A1, SEL_A2: sel_ok = 1'b1;
            default:                                sel_ok = 1'b0;
        endcase
    end

    // section output: b0*x + z0, rounded to sample format
    always_comb begin
        acc_y = (ACC_W'(r_p0) <<< UP_SH) + (ACC_W'(r_z0) <<< DUP_SH) + Y_HALF;
        sh_y  = acc_y >>> Y_SH;
        y_ovf = (sh_y > Y_MAX) || (sh_y < ~Y_MAX);
        y_new = SAMPLE_W'(clamp(sh_y, Y_MAX));
    end

    // new delays: b1*x - a1*y + z1 and b2*x - a2*y, rounded to delay format
    always_comb begin
        acc_z0 = ((ACC_W'(r_p1) - ACC_W'(r_q1)) <<< UP_SH) + (ACC_W'(r_z1) <<< DUP_SH) + Z_HALF;
        acc_z1 = ((ACC_W'(r_p2) - ACC_W'(r_q2)) <<< UP_SH) + Z_HALF;
        sh_z0  = acc_z0 >>> Z_SH;
        sh_z1  = acc_z1 >>> Z_SH;
        z_ovf  = (sh_z0 > Z_MAX) || (sh_z0 < ~Z_MAX) || (sh_z1 > Z_MAX) || (sh_z1 < ~Z_MAX);
        z0_new = DELAY_W'(clamp(sh_z0, Z_MAX));
        z1_new = DELAY_W'(clamp(sh_z1, Z_MAX));
    end

    // valid bits stand in for the all-zero reset of the memories
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef_valid[k] <= '0;
            end
            r_z_valid <= '0;
        end else begin
            if (i_cmd.coef_wr && sel_ok) begin
                r_coef_valid[i_coef_select][i_cmd.coef_sec] <= 1'b1;
            end
            if (i_cmd.delay_clr) begin
                r_z_valid <= '0;
            end else if (i_cmd.upd) begin
                r_z_valid[i_cmd.upd_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && sel_ok) begin
            mem_coef[i_coef_select][i_cmd.coef_sec] <= i_coef_value;
        end
        if (i_cmd.upd) begin
            mem_z0[i_cmd.upd_idx] <= z0_new;
            mem_z1[i_cmd.upd_idx] <= z1_new;
        end
        if (i_cmd.rd_en) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= r_coef_valid[k][i_cmd.rd_idx] ? mem_coef[k][i_cmd.rd_idx] : '0;
            end
            r_z0 <= r_z_valid[i_cmd.rd_idx] ? mem_z0[i_cmd.rd_idx] : '0;
            r_z1 <= r_z_valid[i_cmd.rd_idx] ? mem_z1[i_cmd.rd_idx] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x    <= i_sample_in;
            r_flag <= 1'b0;
        end
        if (i_cmd.mul_x) begin
            r_p0 <= P_W'(r_coef[SEL_B0]) * P_W'(r_x);
            r_p1 <= P_W'(r_coef[SEL_B1]) * P_W'(r_x);
            r_p2 <= P_W'(r_coef[SEL_B2]) * P_W'(r_x);
        end
        if (i_cmd.sat_y) begin
            r_y    <= y_new;
            r_flag <= r_flag | y_ovf;
        end
        if (i_cmd.mul_y) begin
            r_q1 <= P_W'(r_coef[SEL_A1]) * P_W'(r_y);
            r_q2 <= P_W'(r_coef[SEL_A2]) * P_W'(r_y);
        end
        if (i_cmd.upd) begin
            r_x    <= r_y;
            r_flag <= r_flag | z_ovf;
        end
        if (i_cmd.ld_out) begin
            r_res_sample <= r_x;
            r_res_sat    <= r_flag;
        end
    end

    assign o_sample_out = r_res_sample;
    assign o_saturated  = r_res_sat;

endmodule

@@ rtl/cascaded_biquad_iir_filter.sv @@
// cascaded_biquad_iir_filter: top level of the second-order section cascade
// depends on cbq_pkg, cbq_ctrl and cbq_datapath
//
// A cascade of up to MAX_SECTIONS biquads in transposed direct form II. Every input beat
// carries an action in tuser: filter one Q1.15 sample, write one Q4.16 coefficient
// (b0, b1, b2, a1, a2 of one section), or clear all delay values. Only a filter beat
// produces an output beat, carrying the last section's output and a flag set when any
// section output or delay saturated. Write and clear beats act when accepted in idle. A
// filter beat fetches the first section, then runs for each section in use the sequence
// multiply x, round y, multiply y, write delays (fetching the next section), then loads
// the output register; one set of multipliers is shared across all sections, and no new
// beat is accepted until the filter beat is back in idle. The output register lets a
// new beat be accepted while the previous result still waits; a finished result only
// stalls if the prior one has not been taken yet. The user must write num_sections over
// the config port only while the block is idle; the block does not enforce it. 0 acts
// as 1, values above MAX_SECTIONS act as MAX_SECTIONS. Reset is synchronous, active low.
module cascaded_biquad_iir_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config register num_sections
    input  logic                           i_cfg_wr_en,
    input  logic [cbq_pkg::CFG_W-1:0]      i_cfg_wr_data,
    // input beats
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_in, section, coef_value, zero padding
    input  logic [cbq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // action, coef_select
    input  logic [cbq_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    // output beats
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // sample_out, zero padding
    output logic [cbq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // saturated
    output logic                           m_axis_tuser
);
    import cbq_pkg::*;

    t_dp_cmd                    cmd;
    logic [ACTION_W-1:0]        action;
    logic [SEL_W-1:0]           coef_select;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [SECTION_W-1:0]       section;
    logic signed [COEF_W-1:0]   coef_value;
    logic signed [SAMPLE_W-1:0] sample_out;

    // unpack the input beat
    assign action      = s_axis_tuser[ACTION_W-1:0];
    assign coef_select = s_axis_tuser[ACTION_W +: SEL_W];
    assign sample_in   = s_axis_tdata[SAMPLE_W-1:0];
    assign section     = s_axis_tdata[SEC_LSB +: SECTION_W];
    assign coef_value  = s_axis_tdata[COEF_LSB +: COEF_W];

    cbq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_valid     (s_axis_tvalid),
        .i_action      (action),
        .i_section     (section),
        .i_m_ready     (m_axis_tready),
        .o_s_ready     (s_axis_tready),
        .o_m_valid     (m_axis_tvalid),
        .o_cmd         (cmd)
    );

    cbq_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_sample_in   (sample_in),
        .i_coef_select (coef_select),
        .i_coef_value  (coef_value),
        .o_sample_out  (sample_out),
        .o_saturated   (m_axis_tuser)
    );

    // output sample zero-extended to whole bytes
    assign m_axis_tdata = M_TDATA_W'($unsigned(sample_out));

endmodule
